FILE: design/tiil_pkg.sv
// Shared types, constants and the sequencer microprogram for the inverse table lookup.
package tiil_pkg;

	localparam int TABLE_DEPTH_DEF = 512;

	localparam int ENTRY_COUNT_W = 10;
	localparam int ENTRY_INDEX_W = 9;
	localparam int IMP_W         = 16;
	localparam int FREQ_W        = 16;
	localparam int STATUS_W      = 2;
	localparam int DIV_STEPS     = 32;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RST = ENTRY_COUNT_W'(290);

	// APB register map: word index is paddr[2]
	localparam int          PADDR_W         = 3;
	localparam logic        REG_ENTRY_COUNT = 1'b0;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HIGH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LOW  = 2'd2;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [3:0] {
		ACT_WAIT,
		ACT_RD_HI,
		ACT_CHK_HI,
		ACT_CHK_LO,
		ACT_LOOP,
		ACT_CMP,
		ACT_DIFF,
		ACT_MUL,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_FIX,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_QUERY,
		CND_ZGT,
		CND_ZLT,
		CND_SPAN1,
		CND_DEN0,
		CND_CNT_NZ,
		CND_OUT_FREE
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  hold;    // stay on this step when the condition is false
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic query;
		logic zgt;
		logic zlt;
		logic span1;
		logic den0;
		logic cnt_nz;
		logic out_free;
	} flags_t;

	localparam upc_t UPC_WAIT   = 4'd0;
	localparam upc_t UPC_RD_HI  = 4'd1;
	localparam upc_t UPC_LOOP   = 4'd4;
	localparam upc_t UPC_DIFF   = 4'd6;
	localparam upc_t UPC_DIVSTP = 4'd9;
	localparam upc_t UPC_EMIT   = 4'd11;

	function automatic uword_t ucode(input upc_t a);
		uword_t w;
		case (a)
			4'd0:    w = '{ACT_WAIT,     CND_QUERY,    1'b1, UPC_RD_HI};
			4'd1:    w = '{ACT_RD_HI,    CND_NEVER,    1'b0, UPC_WAIT};
			4'd2:    w = '{ACT_CHK_HI,   CND_ZGT,      1'b0, UPC_EMIT};
			4'd3:    w = '{ACT_CHK_LO,   CND_ZLT,      1'b0, UPC_EMIT};
			4'd4:    w = '{ACT_LOOP,     CND_SPAN1,    1'b0, UPC_DIFF};
			4'd5:    w = '{ACT_CMP,      CND_ALWAYS,   1'b0, UPC_LOOP};
			4'd6:    w = '{ACT_DIFF,     CND_DEN0,     1'b0, UPC_EMIT};
			4'd7:    w = '{ACT_MUL,      CND_NEVER,    1'b0, UPC_WAIT};
			4'd8:    w = '{ACT_DIV_INIT, CND_NEVER,    1'b0, UPC_WAIT};
			4'd9:    w = '{ACT_DIV_STEP, CND_CNT_NZ,   1'b0, UPC_DIVSTP};
			4'd10:   w = '{ACT_FIX,      CND_NEVER,    1'b0, UPC_WAIT};
			4'd11:   w = '{ACT_EMIT,     CND_OUT_FREE, 1'b1, UPC_WAIT};
			default: w = '{ACT_WAIT,     CND_ALWAYS,   1'b0, UPC_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: design/table_inverse_interp_lookup.sv
// Top level: inverse impedance-to-frequency table lookup with linear interpolation.
//
// The block holds a table of TABLE_DEPTH impedance/frequency pairs (Q8.8 ohms, Q12.4 Hz)
// in one on-chip RAM with no reset; every entry must be loaded before a query can reach
// it. A load transaction (operation = 1) writes one pair in the cycle it is accepted and
// returns nothing; an index at or beyond TABLE_DEPTH is dropped. A query transaction
// (operation = 0) returns one result: status 1 when the impedance lies above the last
// used entry, status 2 when below entry 0 (frequency zero in both cases), else status 0
// and the frequency interpolated between the bracketing pair, truncated toward zero and
// saturated to 0..65535; equal bracketing impedances return the lower frequency.
// entry_count (APB, byte address 0) sets the entries in use, clamped to 2..TABLE_DEPTH;
// write it only while no query is in flight. Control is a 12-step microprogram driving a
// single datapath. A query runs range checks against the last used entry and entry 0,
// then ceil(log2(n-1)) binary search steps, each a registered RAM read and a compare,
// with a span check before each and after the last, then setup and multiply, the
// bit-serial divider, and a final fix and emit; an out-of-range query goes straight to
// the emit step. Loads are accepted back to back while the sequencer waits; the next
// transaction is taken once it is back in its wait step. A result sits in an output
// register, so the next transaction is accepted while it waits to be taken.
module table_inverse_interp_lookup
	import tiil_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// input transactions
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [ENTRY_INDEX_W-1:0]  entry_index,
	input  logic [IMP_W-1:0]          impedance,
	input  logic [FREQ_W-1:0]         frequency,
	// result transactions
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [FREQ_W-1:0]         result_frequency
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	// count width: holds TABLE_DEPTH itself and any entry_count / entry_index value
	localparam int CW = (IDX_W + 1 > ENTRY_COUNT_W) ? IDX_W + 1 : ENTRY_COUNT_W;

	// ---------------------------------------------------------------- config
	logic [ENTRY_COUNT_W-1:0] entry_count_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
	assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(entry_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
		end else if (cfg_wr) begin
			entry_count_q <= pwdata[ENTRY_COUNT_W-1:0];
		end
	end

	// effective entry count, clamped to 2..TABLE_DEPTH; search starts at hi = n-1
	logic [CW-1:0]    n_c;
	logic [CW-1:0]    n_m1_c;
	logic [IDX_W-1:0] hi_init;

	always_comb begin
		n_c = CW'(entry_count_q);
		if (n_c < CW'(2))
			n_c = CW'(2);
		if (n_c > CW'(TABLE_DEPTH))
			n_c = CW'(TABLE_DEPTH);
	end
	assign n_m1_c  = n_c - CW'(1);
	assign hi_init = n_m1_c[IDX_W-1:0];

	// ---------------------------------------------------------------- sequencer
	uword_t uw;
	flags_t flags;

	tiil_useq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.uw    (uw)
	);

	// ---------------------------------------------------------------- table RAM
	// {impedance, frequency} per entry, one write and one registered read port
	logic [IMP_W+FREQ_W-1:0] mem [TABLE_DEPTH];
	logic [IMP_W+FREQ_W-1:0] rd_q;
	logic [IDX_W-1:0]        rd_addr;
	logic [CW-1:0]           ld_idx_ext;
	logic                    accept;
	logic                    mem_we;
	logic [IMP_W-1:0]        rd_z;
	logic [FREQ_W-1:0]       rd_f;

	assign in_ready   = (uw.act == ACT_WAIT);
	assign accept     = in_valid && in_ready;
	assign ld_idx_ext = CW'(entry_index);
	assign mem_we     = accept && (operation == OP_LOAD) && (ld_idx_ext < CW'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ld_idx_ext[IDX_W-1:0]] <= {impedance, frequency};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_z = rd_q[IMP_W+FREQ_W-1:FREQ_W];
	assign rd_f = rd_q[FREQ_W-1:0];

	// ---------------------------------------------------------------- search
	logic [IMP_W-1:0]  z_q;
	logic [IDX_W-1:0]  lo_q, hi_q;
	logic [IDX_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  span;
	logic [IMP_W-1:0]  zlo_q, zhi_q;
	logic [FREQ_W-1:0] flo_q, fhi_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign span    = hi_q - lo_q;

	always_comb begin
		case (uw.act)
			ACT_RD_HI:  rd_addr = hi_q;
			ACT_CHK_HI: rd_addr = lo_q;
			default:    rd_addr = mid;
		endcase
	end

	// ---------------------------------------------------------------- arithmetic
	logic signed [IMP_W:0]        dz_c, df_c, den_c;
	logic signed [IMP_W:0]        dz_q, df_q, den_q;
	logic signed [2*IMP_W+1:0]    prod_q;
	logic        [2*IMP_W+1:0]    prod_mag;
	logic        [IMP_W:0]        den_mag;
	logic                         neg_q;
	logic        [DIV_STEPS-1:0]  quo_q;
	logic        [IMP_W-1:0]      rem_q;
	logic        [IMP_W-1:0]      dmag_q;
	logic        [DIV_CNT_W-1:0]  cnt_q;
	logic        [IMP_W:0]        trial;
	logic                         trial_ge;
	logic        [DIV_STEPS:0]    qv;
	logic signed [DIV_STEPS+1:0]  sum_c;
	logic        [FREQ_W-1:0]     sat_c;

	assign dz_c  = {1'b0, z_q} - {1'b0, zlo_q};
	assign df_c  = {1'b0, fhi_q} - {1'b0, flo_q};
	assign den_c = {1'b0, zhi_q} - {1'b0, zlo_q};

	assign prod_mag = prod_q[2*IMP_W+1] ? -prod_q : prod_q;
	assign den_mag  = den_q[IMP_W] ? -den_q : den_q;

	// restoring divide, one quotient bit per step
	assign trial    = {rem_q, quo_q[DIV_STEPS-1]};
	assign trial_ge = (trial >= {1'b0, dmag_q});

	assign qv    = neg_q ? ((DIV_STEPS+1)'(0) - {1'b0, quo_q}) : {1'b0, quo_q};
	assign sum_c = $signed({qv[DIV_STEPS], qv}) + $signed((DIV_STEPS+2)'(flo_q));

	always_comb begin
		if (sum_c[DIV_STEPS+1])
			sat_c = '0;
		else if (|sum_c[DIV_STEPS:FREQ_W])
			sat_c = '1;
		else
			sat_c = sum_c[FREQ_W-1:0];
	end

	// ---------------------------------------------------------------- flags
	assign flags.query    = accept && (operation == OP_QUERY);
	assign flags.zgt      = (z_q > rd_z);
	assign flags.zlt      = (z_q < rd_z);
	assign flags.span1    = (span <= IDX_W'(1));
	assign flags.den0     = (den_c == '0);
	assign flags.cnt_nz   = (cnt_q != '0);
	assign flags.out_free = !out_valid || out_ready;

	// ---------------------------------------------------------------- datapath
	logic [STATUS_W-1:0] res_st_q;
	logic [FREQ_W-1:0]   res_f_q;

	always_ff @(posedge clk) begin
		case (uw.act)
			ACT_WAIT: begin
				z_q  <= impedance;
				lo_q <= '0;
				hi_q <= hi_init;
			end
			ACT_CHK_HI: begin
				zhi_q    <= rd_z;
				fhi_q    <= rd_f;
				res_st_q <= ST_HIGH;
				res_f_q  <= '0;
			end
			ACT_CHK_LO: begin
				zlo_q    <= rd_z;
				flo_q    <= rd_f;
				res_st_q <= ST_LOW;
				res_f_q  <= '0;
			end
			ACT_CMP: begin
				if (flags.zgt) begin
					lo_q  <= mid;
					zlo_q <= rd_z;
					flo_q <= rd_f;
				end else begin
					hi_q  <= mid;
					zhi_q <= rd_z;
					fhi_q <= rd_f;
				end
			end
			ACT_DIFF: begin
				dz_q     <= dz_c;
				df_q     <= df_c;
				den_q    <= den_c;
				res_st_q <= ST_OK;
				res_f_q  <= flo_q;   // flat segment result
			end
			ACT_MUL: begin
				prod_q <= dz_q * df_q;
			end
			ACT_DIV_INIT: begin
				neg_q  <= prod_q[2*IMP_W+1] ^ den_q[IMP_W];
				quo_q  <= prod_mag[DIV_STEPS-1:0];
				dmag_q <= den_mag[IMP_W-1:0];
				rem_q  <= '0;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end
			ACT_DIV_STEP: begin
				rem_q <= trial_ge ? (trial[IMP_W-1:0] - dmag_q) : trial[IMP_W-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], trial_ge};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			ACT_FIX: begin
				res_st_q <= ST_OK;
				res_f_q  <= sat_c;
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- output register
	logic out_load;

	assign out_load = (uw.act == ACT_EMIT) && flags.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status           <= res_st_q;
			result_frequency <= res_f_q;
		end
	end

endmodule

FILE: design/tiil_useq.sv
// Microcode sequencer: step counter, control store and conditional branching.
module tiil_useq
	import tiil_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output uword_t uw
);

	upc_t upc_q;
	logic taken;

	assign uw = ucode(upc_q);

	always_comb begin
		case (uw.cond)
			CND_NEVER:    taken = 1'b0;
			CND_ALWAYS:   taken = 1'b1;
			CND_QUERY:    taken = flags.query;
			CND_ZGT:      taken = flags.zgt;
			CND_ZLT:      taken = flags.zlt;
			CND_SPAN1:    taken = flags.span1;
			CND_DEN0:     taken = flags.den0;
			CND_CNT_NZ:   taken = flags.cnt_nz;
			CND_OUT_FREE: taken = flags.out_free;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_WAIT;
		end else if (taken) begin
			upc_q <= uw.target;
		end else if (!uw.hold) begin
			upc_q <= upc_q + upc_t'(1);
		end
	end

endmodule

FILE: dv/tb_table_inverse_interp_lookup.sv
`timescale 1ns / 1ps
// Self-checking testbench for table_inverse_interp_lookup: table loads and lookups vs a predictor.
module tb_table_inverse_interp_lookup;
	import tiil_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 12;
	// Long enough for the worst query at 512 entries and the return to the wait step.
	localparam int SETTLE_CYCLES = 80;
	// Cycles with no transaction on any port before the run is declared hung.
	localparam int STALL_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 200;
	localparam int TAIL_ITEMS    = 100;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_REPORTS   = 200;

	localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = PADDR_W'({REG_ENTRY_COUNT, 2'b00});

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [FREQ_W-1:0]   freq;
	} lookup_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [PADDR_W-1:0]       paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_ready;
	logic                     operation;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic [IMP_W-1:0]         impedance;
	logic [FREQ_W-1:0]        frequency;
	logic                     out_valid;
	logic                     out_ready;
	logic [STATUS_W-1:0]      status;
	logic [FREQ_W-1:0]        result_frequency;

	table_inverse_interp_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH_DEF)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.entry_index     (entry_index),
		.impedance       (impedance),
		.frequency       (frequency),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.result_frequency(result_frequency)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block state, updated as transactions are accepted
	// ------------------------------------------------------------------
	logic [IMP_W-1:0]         imp_tbl [TABLE_DEPTH_DEF];
	logic [FREQ_W-1:0]        frq_tbl [TABLE_DEPTH_DEF];
	logic [ENTRY_COUNT_W-1:0] entry_count_q;

	// Lookup results still owed by the block, oldest first.
	lookup_result_t expected_lookups [$];

	int error_count;
	int idle_cycles;
	int random_items;
	bit src_idle_en;
	bit sink_idle_en;
	int hold_request;      // long receiver hold-off, picked up by the sink process

	// entry_count is clamped to 2..depth on use, not on write.
	function automatic int unsigned entries_in_use();
		int unsigned n;
		n = entry_count_q;
		if (n < 2)
			n = 2;
		if (n > TABLE_DEPTH_DEF)
			n = TABLE_DEPTH_DEF;
		return n;
	endfunction

	// Range checks against the end entries, binary search for the bracket, then a
	// signed interpolation with truncating divide and saturation to 16 bits.
	function automatic lookup_result_t predict_lookup(input logic [IMP_W-1:0] z);
		lookup_result_t r;
		int unsigned    n, lo, hi, mid;
		longint         z_lo, z_hi, f_lo, f_hi, den, val;
		n      = entries_in_use();
		r.st   = ST_OK;
		r.freq = '0;
		if (z > imp_tbl[n-1]) begin
			r.st = ST_HIGH;
		end else if (z < imp_tbl[0]) begin
			r.st = ST_LOW;
		end else begin
			lo = 0;
			hi = n - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (z > imp_tbl[mid])
					lo = mid;
				else
					hi = mid;
			end
			z_lo = longint'(imp_tbl[lo]);
			z_hi = longint'(imp_tbl[hi]);
			f_lo = longint'(frq_tbl[lo]);
			f_hi = longint'(frq_tbl[hi]);
			den  = z_hi - z_lo;
			// flat bracket: no slope, hold the lower frequency
			if (den == 0)
				val = f_lo;
			else
				val = f_lo + ((longint'(z) - z_lo) * (f_hi - f_lo)) / den;
			if (val < 0)
				val = 0;
			if (val > 65535)
				val = 65535;
			r.freq = FREQ_W'(val);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
	endtask

	// ------------------------------------------------------------------
	// Input channel: one transaction per call. Called at a falling edge and
	// returns at one; valid stays high between back-to-back transactions.
	// ------------------------------------------------------------------
	task automatic send_item(input logic op, input logic [ENTRY_INDEX_W-1:0] idx,
			input logic [IMP_W-1:0] z, input logic [FREQ_W-1:0] f);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		impedance   <= z;
		frequency   <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// accepted at this edge: update the shadow table or queue the lookup
		if (op == OP_LOAD) begin
			imp_tbl[idx] = z;
			frq_tbl[idx] = f;
		end else begin
			expected_lookups.push_back(predict_lookup(z));
		end
		@(negedge clk);
	endtask

	// Query with the ignored fields filled with noise.
	task automatic send_query(input logic [IMP_W-1:0] z);
		send_item(OP_QUERY, ENTRY_INDEX_W'($urandom), z, FREQ_W'($urandom));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(negedge clk);
	endtask

	// Quiet block: nothing owed, and a trailing load given time to land.
	task automatic wait_idle();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB: setup cycle then access cycle; pready is tied high in the block
	// ------------------------------------------------------------------
	task automatic reg_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ENTRY_COUNT_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_entry_count();
		logic [31:0] rd;
		reg_access(1'b0, 32'd0, rd);
		if (rd !== 32'(entry_count_q))
			report_mismatch("entry_count readback", 32'(entry_count_q), rd);
	endtask

	task automatic write_entry_count(input logic [ENTRY_COUNT_W-1:0] val);
		logic [31:0] rd;
		wait_idle();
		reg_access(1'b1, 32'(val), rd);
		entry_count_q = val;
		check_entry_count();
	endtask

	// ------------------------------------------------------------------
	// Result channel: receiver stalls and checker
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end
			if (stall == 0 && sink_idle_en && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		lookup_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lookups.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result mismatch: expected none, actual status %0d freq %0d",
						$time, status, result_frequency);
			end else begin
				exp_r = expected_lookups.pop_front();
				if (status !== exp_r.st)
					report_mismatch("status", 32'(exp_r.st), 32'(status));
				if (result_frequency !== exp_r.freq)
					report_mismatch("result_frequency", 32'(exp_r.freq), 32'(result_frequency));
			end
		end
	end

	// Hang detector: any handshake on any port counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("table_inverse_interp_lookup regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_reset_value();
		check_entry_count();
	endtask

	// Two-entry table: both range exits, exact hits on both ends, clamped
	// counts below two, and a flat bracket.
	task automatic test_two_entry_edges();
		write_entry_count(10'd2);
		send_item(OP_LOAD, 9'd0, 16'h0100, 16'h0000);
		send_item(OP_LOAD, 9'd1, 16'hFF00, 16'hFFFF);
		send_query(16'h0000);        // below entry 0
		send_query(16'hFFFF);        // above last entry
		send_query(16'h0100);        // on entry 0
		send_query(16'hFF00);        // on last entry
		send_item(OP_QUERY, 9'h1FF, 16'h8000, 16'hFFFF);
		write_entry_count(10'd0);    // acts as 2
		send_query(16'h7F00);
		write_entry_count(10'd1);    // acts as 2
		send_query(16'h00FF);
		send_query(16'h4000);
		// equal bracketing impedances return the lower frequency
		send_item(OP_LOAD, 9'd0, 16'h1234, 16'h0042);
		send_item(OP_LOAD, 9'd1, 16'h1234, 16'h9999);
		send_query(16'h1234);
		send_query(16'h1235);
		send_query(16'h1233);
	endtask

	// Keys out of order: the search still runs over whatever is stored.
	task automatic test_non_ascending();
		write_entry_count(10'd4);
		send_item(OP_LOAD, 9'd0, 16'h1000, 16'h0800);
		send_item(OP_LOAD, 9'd1, 16'h9000, 16'hF000);
		send_item(OP_LOAD, 9'd2, 16'h0800, 16'h0010);
		send_item(OP_LOAD, 9'd3, 16'h8000, 16'h4000);
		send_query(16'h7000);
		send_query(16'h2000);
		send_query(16'h0C00);
	endtask

	// Whole table loaded, then counts at and beyond the depth, and the reset count.
	task automatic test_full_table();
		int i;
		write_entry_count(10'd512);
		for (i = TABLE_DEPTH_DEF - 1; i >= 0; i--) begin
			if (i == 0)
				send_item(OP_LOAD, 9'd0, 16'h0000, 16'h0000);
			else if (i == TABLE_DEPTH_DEF - 1)
				send_item(OP_LOAD, 9'h1FF, 16'hFFFF, 16'hFFFF);
			else
				send_item(OP_LOAD, ENTRY_INDEX_W'(i),
					IMP_W'(i * 128 + $urandom_range(0, 127)), FREQ_W'($urandom));
		end
		send_query(16'h0000);
		send_query(16'hFFFF);
		repeat (4) send_query(IMP_W'($urandom));
		write_entry_count(10'd1023);
		repeat (3) send_query(IMP_W'($urandom));
		write_entry_count(10'd513);
		repeat (3) send_query(IMP_W'($urandom));
		write_entry_count(ENTRY_COUNT_RST);
		send_query(imp_tbl[289]);
		repeat (3) send_query(IMP_W'($urandom));
	endtask

	// One setting of entry_count: rebuild an ascending table over the used
	// entries (with repeated keys now and then), then mostly in-range queries,
	// order-keeping reloads, and a share of loads with random content anywhere.
	task automatic run_random_phase(input logic [ENTRY_COUNT_W-1:0] cfg, input int items);
		int unsigned n, i, z, step, max_step, sel, idx, lo_b, hi_b;
		write_entry_count(cfg);
		n        = entries_in_use();
		z        = $urandom_range(0, 4095);
		max_step = ((65535 - z) * 2) / n;
		if (max_step < 1)
			max_step = 1;
		for (i = 0; i < n; i++) begin
			if (i != 0) begin
				step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_step);
				z    = (z + step > 65535) ? 65535 : z + step;
			end
			send_item(OP_LOAD, ENTRY_INDEX_W'(i), IMP_W'(z), FREQ_W'($urandom));
		end
		random_items += n;
		for (i = 0; i < items; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				sel = $urandom_range(0, 99);
				if (sel < 75)
					z = $urandom_range(imp_tbl[0], imp_tbl[n-1]);
				else if (sel < 87)
					z = imp_tbl[$urandom_range(0, n - 1)];
				else
					z = $urandom_range(0, 65535);
				send_query(IMP_W'(z));
			end else if (sel < 88) begin
				idx  = $urandom_range(0, n - 1);
				lo_b = (idx == 0) ? 0 : imp_tbl[idx-1];
				hi_b = (idx == n - 1) ? 65535 : imp_tbl[idx+1];
				send_item(OP_LOAD, ENTRY_INDEX_W'(idx), IMP_W'($urandom_range(lo_b, hi_b)),
					FREQ_W'($urandom));
			end else begin
				send_item(OP_LOAD, ENTRY_INDEX_W'($urandom), IMP_W'($urandom),
					FREQ_W'($urandom));
			end
		end
		random_items += items;
	endtask

	// Mostly small tables; the depth and the over-range counts come up rarely.
	task automatic test_random_traffic(input int total);
		int unsigned sel, cfg;
		while (random_items < total) begin
			sel = $urandom_range(0, 19);
			case (sel)
				0:                         cfg = $urandom_range(0, 1);
				1, 2, 3:                   cfg = $urandom_range(2, 8);
				4, 5, 6, 7, 8, 9, 10, 11, 12: cfg = $urandom_range(9, 40);
				13, 14, 15, 16:            cfg = $urandom_range(41, 200);
				17, 18:                    cfg = $urandom_range(201, 512);
				default:                   cfg = $urandom_range(513, 1023);
			endcase
			src_idle_en  = ($urandom_range(0, 4) != 0);
			sink_idle_en = ($urandom_range(0, 4) != 0);
			run_random_phase(ENTRY_COUNT_W'(cfg), $urandom_range(40, 90));
		end
	endtask

	// Receiver holds off long enough for the block to back up and stall its
	// input; then the sender pauses until every owed result has come out.
	task automatic test_output_backpressure();
		int unsigned n;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		wait_idle();
		n            = entries_in_use();
		hold_request = LONG_HOLD;
		repeat (12) send_query(IMP_W'($urandom_range(imp_tbl[0], imp_tbl[n-1])));
		wait_results_drained();
		repeat (6) send_query(IMP_W'($urandom_range(imp_tbl[0], imp_tbl[n-1])));
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_streaming_tail();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random_phase(ENTRY_COUNT_W'($urandom_range(9, 64)), TAIL_ITEMS);
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		operation     = OP_QUERY;
		entry_index   = '0;
		impedance     = '0;
		frequency     = '0;
		error_count   = 0;
		idle_cycles   = 0;
		random_items  = 0;
		src_idle_en   = 1'b1;
		sink_idle_en  = 1'b1;
		hold_request  = 0;
		entry_count_q = ENTRY_COUNT_RST;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_value();
		test_two_entry_edges();
		test_non_ascending();
		test_full_table();
		test_random_traffic(RANDOM_ITEMS);
		test_output_backpressure();
		test_streaming_tail();

		// everything owed must arrive; a hang here ends in the watchdog
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("table_inverse_interp_lookup regression: pass");
		else
			$display("table_inverse_interp_lookup regression: fail");
		$finish;
	end

endmodule
